FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted encoder tick tracker package
// Shared widths, reset values, register indexes, scaling constants and the
// structs that travel between the tracker modules.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Default sizes for the parameterized widths.
	localparam int SAMPLE_BITS_DEF   = 10;
	localparam int POSITION_BITS_DEF = 6;

	// Fixed field widths.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int TIME_BITS      = 32;
	localparam int INTERVAL_BITS  = 16;
	localparam int ROT_BITS       = 16;
	localparam int SPEED_BITS     = 7;
	localparam int DUTY_BITS      = 8;

	// Register reset values.
	localparam int HIGH_THRESHOLD_RST  = 800;
	localparam int LOW_THRESHOLD_RST   = 300;
	localparam int SLOTS_PER_TURN_RST  = 38;
	localparam int TARGET_INTERVAL_RST = 7750;
	localparam int BASE_SPEED_RST      = 55;
	localparam int MIN_SPEED_RST       = 35;
	localparam int MAX_SPEED_RST       = 100;

	// Interval error gain: divide by GainDiv through a reciprocal multiply.
	// Exact for every 16-bit magnitude.
	localparam int GainDiv       = 50;
	localparam int DIV_SHIFT     = 22;
	localparam int DIV_MULT_BITS = 17;
	localparam logic [DIV_MULT_BITS-1:0] DIV_MULT =
		DIV_MULT_BITS'(((1 << DIV_SHIFT) + GainDiv - 1) / GainDiv);

	// Percent to duty: floor(m * 255 / 100) as one constant multiply and shift.
	localparam int DutyFull        = 255;
	localparam int PercentFull     = 100;
	localparam int DUTY_SHIFT      = 19;
	localparam int DUTY_MULT_BITS  = 21;
	localparam logic [DUTY_MULT_BITS-1:0] DUTY_MULT = DUTY_MULT_BITS'(DutyFull *
		(((1 << DUTY_SHIFT) + PercentFull - 1) / PercentFull));

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_HIGH_THRESHOLD  = 3'd0,
		REG_LOW_THRESHOLD   = 3'd1,
		REG_SLOTS_PER_TURN  = 3'd2,
		REG_TARGET_INTERVAL = 3'd3,
		REG_BASE_SPEED      = 3'd4,
		REG_MIN_SPEED       = 3'd5,
		REG_MAX_SPEED       = 3'd6,
		REG_PAUSED          = 3'd7
	} cfg_reg_t;

	// Speed control settings.
	typedef struct packed {
		logic [INTERVAL_BITS-1:0] target_interval;
		logic [SPEED_BITS-1:0]    base_speed;
		logic [SPEED_BITS-1:0]    min_speed;
		logic [SPEED_BITS-1:0]    max_speed;
	} speed_cfg_t;

	// New drive: direction and clamped speed magnitude in percent.
	typedef struct packed {
		logic                  forward;
		logic [SPEED_BITS-1:0] mag;
	} drive_t;

	// Tracker result for one request, before duty scaling.
	typedef struct packed {
		logic                     tick;
		logic [ROT_BITS-1:0]      rotation_count;
		logic [INTERVAL_BITS-1:0] interval;
		logic                     forward;
		logic [SPEED_BITS-1:0]    mag;
	} track_t;

endpackage

FILE: rtl/stt_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder sample channel
// Valid/ready channel that carries one encoder sample and its timestamp.
// ----------------------------------------------------------------------------
interface stt_sample_if
	import stt_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] encoder_sample;
	logic [TIME_BITS-1:0]   time_us;

	modport source (output valid, output encoder_sample, output time_us, input ready);
	modport sink   (input valid, input encoder_sample, input time_us, output ready);
endinterface

FILE: rtl/stt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel that carries tick, position, rotations, interval and drive.
// ----------------------------------------------------------------------------
interface stt_result_if
	import stt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) ();
	logic                     valid;
	logic                     ready;
	logic                     tick;
	logic [POSITION_BITS-1:0] position;
	logic [ROT_BITS-1:0]      rotation_count;
	logic [INTERVAL_BITS-1:0] interval;
	logic                     forward;
	logic [DUTY_BITS-1:0]     duty;

	modport source (
		output valid, output tick, output position, output rotation_count,
		output interval, output forward, output duty, input ready
	);
	modport sink (
		input valid, input tick, input position, input rotation_count,
		input interval, input forward, input duty, output ready
	);
endinterface

FILE: rtl/stt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for thresholds, slot count, speed control and pause.
// ----------------------------------------------------------------------------
module stt_cfg_regs
	import stt_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	output logic [SAMPLE_BITS-1:0]    high_threshold,
	output logic [SAMPLE_BITS-1:0]    low_threshold,
	output logic [POSITION_BITS-1:0]  slots_per_turn,
	output logic                      paused,
	output speed_cfg_t                speed_cfg
);
	logic [SAMPLE_BITS-1:0]   high_q;
	logic [SAMPLE_BITS-1:0]   low_q;
	logic [POSITION_BITS-1:0] tpr_q;
	logic                     paused_q;
	speed_cfg_t               speed_q;

	// Register writes; each register keeps the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q                 <= SAMPLE_BITS'(HIGH_THRESHOLD_RST);
			low_q                  <= SAMPLE_BITS'(LOW_THRESHOLD_RST);
			tpr_q                  <= POSITION_BITS'(SLOTS_PER_TURN_RST);
			paused_q               <= 1'b0;
			speed_q.target_interval <= INTERVAL_BITS'(TARGET_INTERVAL_RST);
			speed_q.base_speed     <= SPEED_BITS'(BASE_SPEED_RST);
			speed_q.min_speed      <= SPEED_BITS'(MIN_SPEED_RST);
			speed_q.max_speed      <= SPEED_BITS'(MAX_SPEED_RST);
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_HIGH_THRESHOLD:  high_q <= wr_data[SAMPLE_BITS-1:0];
				REG_LOW_THRESHOLD:   low_q <= wr_data[SAMPLE_BITS-1:0];
				REG_SLOTS_PER_TURN:  tpr_q <= wr_data[POSITION_BITS-1:0];
				REG_TARGET_INTERVAL: speed_q.target_interval <= wr_data[INTERVAL_BITS-1:0];
				REG_BASE_SPEED:      speed_q.base_speed <= wr_data[SPEED_BITS-1:0];
				REG_MIN_SPEED:       speed_q.min_speed <= wr_data[SPEED_BITS-1:0];
				REG_MAX_SPEED:       speed_q.max_speed <= wr_data[SPEED_BITS-1:0];
				REG_PAUSED:          paused_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign high_threshold = high_q;
	assign low_threshold  = low_q;
	assign slots_per_turn = tpr_q;
	assign paused         = paused_q;
	assign speed_cfg      = speed_q;
endmodule

FILE: rtl/stt_drive_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive calculation
// Turns a tick interval into a motor direction and a clamped speed magnitude.
// ----------------------------------------------------------------------------
module stt_drive_calc
	import stt_pkg::*;
(
	input  logic [INTERVAL_BITS-1:0] interval,
	input  speed_cfg_t               speed_cfg,
	output drive_t                   drive
);
	localparam int PROD_BITS  = INTERVAL_BITS + DIV_MULT_BITS;
	localparam int QUOT_BITS  = 11;
	localparam int DRIVE_BITS = 13;

	logic signed [INTERVAL_BITS:0]   err;
	logic        [INTERVAL_BITS:0]   err_neg;
	logic        [INTERVAL_BITS-1:0] err_mag;
	logic        [PROD_BITS-1:0]     quot_prod;
	logic        [QUOT_BITS-1:0]     quot;
	logic signed [DRIVE_BITS-1:0]    quot_signed;
	logic signed [DRIVE_BITS-1:0]    drive_val;
	logic        [DRIVE_BITS-1:0]    drive_neg;
	logic        [DRIVE_BITS-2:0]    mag_full;
	logic        [DRIVE_BITS-2:0]    mag_min;
	logic        [DRIVE_BITS-2:0]    min_ext;
	logic        [DRIVE_BITS-2:0]    max_ext;

	always_comb begin
		// Signed error, then quotient toward zero on the magnitude.
		err       = $signed({1'b0, interval}) - $signed({1'b0, speed_cfg.target_interval});
		err_neg   = -err;
		err_mag   = err[INTERVAL_BITS] ? err_neg[INTERVAL_BITS-1:0] : err[INTERVAL_BITS-1:0];
		quot_prod = PROD_BITS'(err_mag) * PROD_BITS'(DIV_MULT);
		quot      = quot_prod[DIV_SHIFT +: QUOT_BITS];

		// Restore the sign and add the base speed.
		quot_signed = err[INTERVAL_BITS] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
		drive_val   = quot_signed
			+ $signed({{(DRIVE_BITS - SPEED_BITS){1'b0}}, speed_cfg.base_speed});
		drive_neg   = -drive_val;
		mag_full    = drive_val[DRIVE_BITS-1] ? drive_neg[DRIVE_BITS-2:0]
			: drive_val[DRIVE_BITS-2:0];

		// Minimum clamp for nonzero drive, then the maximum clamp wins.
		min_ext = {{(DRIVE_BITS - 1 - SPEED_BITS){1'b0}}, speed_cfg.min_speed};
		max_ext = {{(DRIVE_BITS - 1 - SPEED_BITS){1'b0}}, speed_cfg.max_speed};
		mag_min = (mag_full != '0 && mag_full < min_ext) ? min_ext : mag_full;

		drive.forward = !drive_val[DRIVE_BITS-1] && (drive_val != '0);
		drive.mag     = (mag_min > max_ext) ? speed_cfg.max_speed : mag_min[SPEED_BITS-1:0];
	end
endmodule

FILE: rtl/stt_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick tracker core
// Hysteresis tick detector, position and rotation counter, interval timer and
// drive state. State moves one sample per step.
// ----------------------------------------------------------------------------
module stt_tracker
	import stt_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic [TIME_BITS-1:0]     time_us,
	input  logic [SAMPLE_BITS-1:0]   high_threshold,
	input  logic [SAMPLE_BITS-1:0]   low_threshold,
	input  logic [POSITION_BITS-1:0] slots_per_turn,
	input  logic                     paused,
	input  speed_cfg_t               speed_cfg,
	output logic [POSITION_BITS-1:0] position,
	output track_t                   track
);
	logic                     armed_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [ROT_BITS-1:0]      rot_q;
	logic [TIME_BITS-1:0]     last_time_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic                     forward_q;
	logic [SPEED_BITS-1:0]    mag_q;
	logic                     tick_s2;

	logic                     fire;
	logic                     rearm;
	logic [TIME_BITS-1:0]     dt;
	logic [INTERVAL_BITS-1:0] interval_new;
	logic [POSITION_BITS-1:0] last_pos;
	logic [POSITION_BITS-1:0] pos_next;
	logic [ROT_BITS-1:0]      rot_next;
	drive_t                   drive;

	// Detector: the fire test comes before the re-arm test.
	always_comb begin
		fire  = !paused && armed_q && (sample < low_threshold);
		rearm = !paused && !fire && (sample > high_threshold);
	end

	// Interval since the last tick, saturated to 16 bits.
	always_comb begin
		dt           = time_us - last_time_q;
		interval_new = (|dt[TIME_BITS-1:INTERVAL_BITS]) ? '1 : dt[INTERVAL_BITS-1:0];
	end

	// Position step in the held direction; fewer than two slots act as one.
	always_comb begin
		last_pos = (slots_per_turn == '0) ? '0 : slots_per_turn - 1'b1;
		pos_next = pos_q;
		rot_next = rot_q;
		if (forward_q) begin
			if (pos_q >= last_pos) begin
				pos_next = '0;
				rot_next = rot_q + 1'b1;
			end else begin
				pos_next = pos_q + 1'b1;
			end
		end else begin
			if (pos_q == '0) begin
				pos_next = last_pos;
				rot_next = rot_q - 1'b1;
			end else begin
				pos_next = pos_q - 1'b1;
			end
		end
	end

	stt_drive_calc u_drive (
		.interval  (interval_new),
		.speed_cfg (speed_cfg),
		.drive     (drive)
	);

	// Tracker state; it changes only when a request moves through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			pos_q       <= '0;
			rot_q       <= '0;
			last_time_q <= '0;
			interval_q  <= '0;
			forward_q   <= 1'b1;
			mag_q       <= '0;
			tick_s2     <= 1'b0;
		end else if (step) begin
			tick_s2 <= fire;
			if (fire) begin
				armed_q     <= 1'b0;
				pos_q       <= pos_next;
				rot_q       <= rot_next;
				last_time_q <= time_us;
				interval_q  <= interval_new;
				forward_q   <= drive.forward;
				mag_q       <= drive.mag;
			end else if (rearm) begin
				armed_q <= 1'b1;
			end
		end
	end

	assign position             = pos_q;
	assign track.tick           = tick_s2;
	assign track.rotation_count = rot_q;
	assign track.interval       = interval_q;
	assign track.forward        = forward_q;
	assign track.mag            = mag_q;
endmodule

FILE: rtl/stt_duty_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duty output stage
// Scales the speed percent to an 8-bit PWM duty and holds the result request
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module stt_duty_stage
	import stt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     offer,
	input  track_t                   track,
	input  logic [POSITION_BITS-1:0] position,
	output logic                     load,
	stt_result_if.source             results
);
	localparam int PROD_BITS   = SPEED_BITS + DUTY_MULT_BITS;
	localparam int SCALED_BITS = DUTY_BITS + 1;

	logic                     valid_q;
	logic                     tick_q;
	logic [POSITION_BITS-1:0] position_q;
	logic [ROT_BITS-1:0]      rot_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic                     forward_q;
	logic [DUTY_BITS-1:0]     duty_q;

	logic [PROD_BITS-1:0]     duty_prod;
	logic [SCALED_BITS-1:0]   duty_scaled;
	logic [DUTY_BITS-1:0]     duty_new;

	// Percent to duty with saturation for speeds above full scale.
	always_comb begin
		duty_prod   = PROD_BITS'(track.mag) * PROD_BITS'(DUTY_MULT);
		duty_scaled = duty_prod[DUTY_SHIFT +: SCALED_BITS];
		duty_new    = (duty_scaled > SCALED_BITS'(DutyFull)) ? DUTY_BITS'(DutyFull)
			: duty_scaled[DUTY_BITS-1:0];
	end

	assign load = offer && (!valid_q || results.ready);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			tick_q     <= track.tick;
			position_q <= position;
			rot_q      <= track.rotation_count;
			interval_q <= track.interval;
			forward_q  <= track.forward;
			duty_q     <= duty_new;
		end
	end

	assign results.valid          = valid_q;
	assign results.tick           = tick_q;
	assign results.position       = position_q;
	assign results.rotation_count = rot_q;
	assign results.interval       = interval_q;
	assign results.forward        = forward_q;
	assign results.duty           = duty_q;
endmodule

FILE: rtl/slotted_encoder_tick_tracker.sv
`timescale 1ns / 1ps
// Path: an accepted sample moves through the input register, tracker
// state and output register. Throughput: one sample per cycle while
// results are taken; the next may enter right behind the current one.
// Reset: arst_n clears the valid flags and restores the config and tracker
// state at once, no clearing pass needed; data registers are not reset.
// ----------------------------------------------------------------------------
// Slotted encoder tick tracker
// Hysteresis tick detection on encoder samples, position and rotation
// counting, tick interval measurement and interval-based motor drive.
// ----------------------------------------------------------------------------
module slotted_encoder_tick_tracker
	import stt_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	stt_sample_if.sink                samples,
	stt_result_if.source              results
);
	logic [SAMPLE_BITS-1:0]   high_threshold;
	logic [SAMPLE_BITS-1:0]   low_threshold;
	logic [POSITION_BITS-1:0] slots_per_turn;
	logic                     paused;
	speed_cfg_t               speed_cfg;

	logic                     valid_s1;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic [TIME_BITS-1:0]     time_s1;
	logic                     valid_s2;

	logic                     take;
	logic                     step;
	logic                     load;
	logic [POSITION_BITS-1:0] position;
	track_t                   track;

	stt_cfg_regs #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.high_threshold (high_threshold),
		.low_threshold  (low_threshold),
		.slots_per_turn (slots_per_turn),
		.paused         (paused),
		.speed_cfg      (speed_cfg)
	);

	// Handshake between the input register, tracker and output register.
	assign step          = valid_s1 && (!valid_s2 || load);
	assign samples.ready = !valid_s1 || step;
	assign take          = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (load) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= samples.encoder_sample;
			time_s1   <= samples.time_us;
		end
	end

	stt_tracker #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.sample         (sample_s1),
		.time_us        (time_s1),
		.high_threshold (high_threshold),
		.low_threshold  (low_threshold),
		.slots_per_turn (slots_per_turn),
		.paused         (paused),
		.speed_cfg      (speed_cfg),
		.position       (position),
		.track          (track)
	);

	stt_duty_stage #(
		.POSITION_BITS (POSITION_BITS)
	) u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.offer    (valid_s2),
		.track    (track),
		.position (position),
		.load     (load),
		.results  (results)
	);
endmodule
